FILE: rtl/core/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DPRL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define DPRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/dprl_pkg.sv
`default_nettype none

package dprl_pkg;

   localparam int SLOTS = 64;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int DATA_W = 32;
   localparam logic [DATA_W-1:0] MIN_INTERVAL_RESET = 32'd300;

   typedef enum logic [1:0] {
      CMD_DIRTY  = 2'd0,
      CMD_TAKE   = 2'd1,
      CMD_PUSHED = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] dirty;
      logic [DATA_W-1:0] pushed;
      logic [DATA_W-1:0] last_time;
   } slot_rec_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] key;
      logic [CNT_W-1:0]  count;
   } scan_req_type;

   typedef struct packed {
      logic             done;
      logic             hit;
      logic [IDX_W-1:0] index;
   } scan_res_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] key;
   } key_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      slot_rec_type     rec;
   } slot_wr_type;

endpackage

`default_nettype wire

FILE: rtl/core/dirty_push_rate_limit_table.sv
// a request passes IDLE, SCAN (key search), EXEC (slot update, skipped when the table is full), RESP
// the scan compares one key per cycle, so the response time grows with the slot position of the key
// one request at a time; req_ready rises with rsp_valid, when RESP hands over the response
// the response register lets a new request start while the last response waits
// reset: synchronous, empties the table (slot count zero) and sets min_interval to 300
`default_nettype none
`include "assert_macros.svh"

module dirty_push_rate_limit_table
   import dprl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [DATA_W-1:0] req_client_key,
   input  wire logic [DATA_W-1:0] req_push_seq,
   input  wire logic [DATA_W-1:0] req_now_time,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_pending,
   output logic [DATA_W-1:0]      rsp_pending_seq,
   output logic                   rsp_table_full,
   input  wire logic              csr_wr_en,
   input  wire logic [DATA_W-1:0] csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] min_interval_ff;
   logic [CNT_W-1:0]  slots_used_ff, slots_used_in;

   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] seq_ff, seq_in;
   logic [DATA_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              new_slot_ff, new_slot_in;
   logic              full_ff, full_in;
   logic              pend_ff, pend_in;
   logic [DATA_W-1:0] pseq_ff, pseq_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_pend_ff, rsp_pend_in;
   logic [DATA_W-1:0] rsp_pseq_ff, rsp_pseq_in;
   logic              rsp_full_ff, rsp_full_in;

   scan_req_type      scan_req;
   scan_res_type      scan_res;
   key_wr_type        key_wr;
   slot_wr_type       slot_wr;
   slot_rec_type      ram_rd_rec;
   logic              ram_rd_en;

   slot_rec_type      rec;
   slot_rec_type      new_rec;
   logic [DATA_W-1:0] elapsed;

   dprl_key_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .key_wr   (key_wr),
      .scan_res (scan_res)
   );

   dprl_slot_ram u_ram (
      .clock    (clock),
      .rd_en    (ram_rd_en),
      .rd_index (scan_res.index),
      .slot_wr  (slot_wr),
      .rd_rec   (ram_rd_rec)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      slots_used_in = slots_used_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      seq_in        = seq_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      new_slot_in   = new_slot_ff;
      full_in       = full_ff;
      pend_in       = pend_ff;
      pseq_in       = pseq_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pend_in   = rsp_pend_ff;
      rsp_pseq_in   = rsp_pseq_ff;
      rsp_full_in   = rsp_full_ff;

      scan_req.start = 1'b0;
      scan_req.key   = req_client_key;
      scan_req.count = slots_used_ff;

      key_wr.en    = 1'b0;
      key_wr.index = slots_used_ff[IDX_W-1:0];
      key_wr.key   = key_ff;

      ram_rd_en = 1'b0;

      rec     = new_slot_ff ? '0 : ram_rd_rec;
      elapsed = now_ff - rec.last_time;
      new_rec = rec;

      slot_wr.en    = 1'b0;
      slot_wr.index = idx_ff;
      slot_wr.rec   = new_rec;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in         = cmd_type'(req_cmd);
               key_in         = req_client_key;
               seq_in         = req_push_seq;
               now_in         = req_now_time;
               scan_req.start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_res.done) begin
               if (scan_res.hit) begin
                  ram_rd_en   = 1'b1;
                  idx_in      = scan_res.index;
                  new_slot_in = 1'b0;
                  state_in    = ST_EXEC;
               end else if (slots_used_ff < CNT_W'(SLOTS)) begin
                  key_wr.en     = 1'b1;
                  idx_in        = slots_used_ff[IDX_W-1:0];
                  new_slot_in   = 1'b1;
                  slots_used_in = slots_used_ff + CNT_W'(1);
                  state_in      = ST_EXEC;
               end else begin
                  full_in  = 1'b1;
                  pend_in  = 1'b0;
                  pseq_in  = '0;
                  state_in = ST_RESP;
               end
            end
         end
         ST_EXEC: begin
            full_in = 1'b0;
            pend_in = 1'b0;
            pseq_in = '0;
            case (cmd_ff)
               CMD_DIRTY: begin
                  new_rec.dirty = rec.dirty + DATA_W'(1);
               end
               CMD_TAKE: begin
                  if ((rec.dirty != rec.pushed) && (elapsed >= min_interval_ff)) begin
                     pend_in = 1'b1;
                     pseq_in = rec.dirty;
                  end
               end
               CMD_PUSHED: begin
                  if (seq_ff > rec.pushed) begin
                     new_rec.pushed    = seq_ff;
                     new_rec.last_time = now_ff;
                  end
               end
               CMD_CLEAR: begin
                  new_rec.pushed    = rec.dirty;
                  new_rec.last_time = now_ff;
               end
               default: begin
                  new_rec = rec;
               end
            endcase
            slot_wr.en  = 1'b1;
            slot_wr.rec = new_rec;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pend_in  = pend_ff;
               rsp_pseq_in  = pseq_ff;
               rsp_full_in  = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         slots_used_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         min_interval_ff <= MIN_INTERVAL_RESET;
      end else begin
         state_ff      <= state_in;
         slots_used_ff <= slots_used_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            min_interval_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      seq_ff      <= seq_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      new_slot_ff <= new_slot_in;
      full_ff     <= full_in;
      pend_ff     <= pend_in;
      pseq_ff     <= pseq_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_pseq_ff <= rsp_pseq_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pending     = rsp_pend_ff;
   assign rsp_pending_seq = rsp_pseq_ff;
   assign rsp_table_full  = rsp_full_ff;

   `DPRL_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, slots_used_ff <= CNT_W'(SLOTS))
   `DPRL_ASSERT_IMP(a_full_only_when_full, clock, reset, rsp_valid_ff && rsp_full_ff, slots_used_ff == CNT_W'(SLOTS))
   `DPRL_ASSERT_IMP(a_hit_in_range, clock, reset, scan_res.done && scan_res.hit, CNT_W'(scan_res.index) < slots_used_ff)
   `DPRL_ASSERT_NEXT(a_transfer_starts_scan, clock, reset, req_valid && req_ready, state_ff == ST_SCAN)

endmodule

`default_nettype wire

FILE: rtl/core/dprl_key_scan.sv
`default_nettype none

module dprl_key_scan
   import dprl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scan_req_type scan_req,
   input  wire key_wr_type   key_wr,
   output scan_res_type      scan_res
);

   logic [DATA_W-1:0] key_mem_ff [SLOTS];

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [DATA_W-1:0] rd_key_ff;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic issue;
   logic hit_now;
   logic miss_now;

   always_comb begin
      issue    = busy_ff && (addr_ff < count_ff);
      hit_now  = busy_ff && rd_valid_ff && (rd_key_ff == key_ff);
      miss_now = busy_ff && !rd_valid_ff && !issue;

      scan_res.done  = hit_now || miss_now;
      scan_res.hit   = hit_now;
      scan_res.index = rd_idx_ff;

      busy_in     = busy_ff;
      addr_in     = addr_ff;
      rd_valid_in = rd_valid_ff;
      key_in      = key_ff;
      count_in    = count_ff;

      if (scan_req.start) begin
         busy_in     = 1'b1;
         addr_in     = '0;
         rd_valid_in = 1'b0;
         key_in      = scan_req.key;
         count_in    = scan_req.count;
      end else if (hit_now || miss_now) begin
         busy_in     = 1'b0;
         rd_valid_in = 1'b0;
      end else if (busy_ff) begin
         rd_valid_in = issue;
         if (issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
         addr_ff     <= '0;
         count_ff    <= '0;
      end else begin
         busy_ff     <= busy_in;
         rd_valid_ff <= rd_valid_in;
         addr_ff     <= addr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (issue) begin
         rd_key_ff <= key_mem_ff[addr_ff[IDX_W-1:0]];
         rd_idx_ff <= addr_ff[IDX_W-1:0];
      end
      if (key_wr.en) begin
         key_mem_ff[key_wr.index] <= key_wr.key;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/dprl_slot_ram.sv
`default_nettype none

module dprl_slot_ram
   import dprl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_index,
   input  wire slot_wr_type      slot_wr,
   output slot_rec_type          rd_rec
);

   slot_rec_type mem_ff [SLOTS];
   slot_rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_rec_ff <= mem_ff[rd_index];
      end
      if (slot_wr.en) begin
         mem_ff[slot_wr.index] <= slot_wr.rec;
      end
   end

   assign rd_rec = rd_rec_ff;

endmodule

`default_nettype wire
